@@ rtl/cq_pkg.sv @@
`default_nettype none

package cq_pkg;

  // Storage geometry
  localparam int unsigned DEPTH  = 1024;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  // Field widths
  localparam int unsigned DATA_W = 32;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned CAP_W  = 11;

  // Capacity register after reset
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

  // Operation codes; any other code acts as a query
  localparam logic [KIND_W-1:0] KIND_ENQ   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DEQ   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

endpackage

`default_nettype wire

@@ rtl/cq_if.sv @@
`default_nettype none

// Request channel: one operation word per handshake
interface cq_req_if;
  import cq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic signed [DATA_W-1:0] push_value;

  modport source (output valid, output kind, output push_value, input ready);
  modport sink   (input valid, input kind, input push_value, output ready);
endinterface

// Response channel: one status word per request
interface cq_rsp_if;
  import cq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     accepted;
  logic signed [DATA_W-1:0] front_value;
  logic signed [DATA_W-1:0] rear_value;
  logic                     is_empty;
  logic                     is_full;

  modport source (output valid, output accepted, output front_value, output rear_value,
                  output is_empty, output is_full, input ready);
  modport sink   (input valid, input accepted, input front_value, input rear_value,
                  input is_empty, input is_full, output ready);
endinterface

`default_nettype wire

@@ rtl/circular_queue.sv @@
// circular_queue: ring-buffer FIFO of signed 32-bit words.
//
// req_i carries one operation per word: enqueue (with push_value), dequeue,
// or query. rsp_o returns exactly one word per request, in order: whether the
// operation was done, the front and rear entries after it (-1 when empty),
// and the empty and full flags.
// cfg_we_i/cfg_wdata_i set the usable capacity (clamped to 1..DEPTH); a write
// empties the queue. Write it only while no request is in flight.
//
// An enqueue, query, refused operation or emptying dequeue has its response
// registered on acceptance; a dequeue that leaves entries behind first passes
// through S_FETCH, since the new front comes from the single read port of the
// entry memory. Throughput: one word per cycle while rsp_o.ready is high and no
// fetch is pending. Front and rear are kept in registers, so only that dequeue
// touches the read port. A pending response holds while rsp_o.ready is low; a
// new request is taken in the same cycle the pending one drains.
// Reset empties the queue and sets the capacity to 1024; memory contents are
// not cleared, no clearing pass is needed.
`default_nettype none

module circular_queue (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  cq_req_if.sink                         req_i,
  cq_rsp_if.source                       rsp_o,
  input  wire logic                      cfg_we_i,
  input  wire logic [cq_pkg::CAP_W-1:0]  cfg_wdata_i
);
  import cq_pkg::*;

  localparam int unsigned CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_FETCH = 2'b10
  } state_e;

  typedef struct packed {
    logic              accepted;
    logic [DATA_W-1:0] front;
    logic [DATA_W-1:0] rear;
    logic              empty;
    logic              full;
  } rsp_t;

  // Wrap a sum of two values below cap into 0..cap-1
  function automatic logic [IDX_W-1:0] wrap_idx(logic [CNT_W:0] sum, logic [CNT_W-1:0] cap);
    logic [CNT_W:0] s;
    s = sum;
    if (s >= {1'b0, cap}) begin
      s = s - {1'b0, cap};
    end
    return s[IDX_W-1:0];
  endfunction

  state_e            state_q, state_d;
  logic [CAP_W-1:0]  cap_q;
  logic [IDX_W-1:0]  head_q, head_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [DATA_W-1:0] front_q, front_d;
  logic [DATA_W-1:0] rear_q, rear_d;
  logic              out_valid_q, out_valid_d;
  rsp_t              out_q, out_d;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;
  logic              mem_we, mem_re;
  logic [IDX_W-1:0]  waddr, raddr;

  logic [CMP_W-1:0]  cap_ext;
  logic [CNT_W-1:0]  cap_eff;
  logic              in_fire, out_fire;
  logic              is_enq, is_deq, q_empty, q_full, enq_ok, deq_ok;

  // Clamp the capacity to 1..DEPTH
  always_comb begin
    cap_ext = CMP_W'(cap_q);
    if (cap_ext == '0) begin
      cap_ext = CMP_W'(1);
    end else if (cap_ext > CMP_W'(DEPTH)) begin
      cap_ext = CMP_W'(DEPTH);
    end
    cap_eff = cap_ext[CNT_W-1:0];
  end

  assign req_i.ready = (state_q == S_IDLE) && (!out_valid_q || rsp_o.ready);
  assign in_fire     = req_i.valid && req_i.ready;
  assign out_fire    = out_valid_q && rsp_o.ready;

  assign is_enq  = (req_i.kind == KIND_ENQ);
  assign is_deq  = (req_i.kind == KIND_DEQ);
  assign q_empty = (count_q == '0);
  assign q_full  = (count_q == cap_eff);
  assign enq_ok  = is_enq && !q_full;
  assign deq_ok  = is_deq && !q_empty;

  assign waddr  = wrap_idx((CNT_W+1)'(head_q) + (CNT_W+1)'(count_q), cap_eff);
  assign mem_we = in_fire && enq_ok;
  assign raddr  = head_d;

  // Apply the operation and pick the next response word
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    front_d     = front_q;
    rear_d      = rear_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_fire;
    mem_re      = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (enq_ok) begin
            count_d = count_q + CNT_W'(1);
            rear_d  = req_i.push_value;
            if (q_empty) begin
              front_d = req_i.push_value;
            end
          end else if (deq_ok) begin
            count_d = count_q - CNT_W'(1);
            head_d  = wrap_idx((CNT_W+1)'(head_q) + (CNT_W+1)'(1), cap_eff);
          end

          if (deq_ok && (count_d != '0)) begin
            // fetch the new front from memory
            mem_re  = 1'b1;
            state_d = S_FETCH;
          end else begin
            out_valid_d    = 1'b1;
            out_d.accepted = !((is_enq && q_full) || (is_deq && q_empty));
            out_d.empty    = (count_d == '0);
            out_d.full     = (count_d == cap_eff);
            out_d.front    = (count_d == '0) ? '1 : front_d;
            out_d.rear     = (count_d == '0) ? '1 : rear_d;
          end
        end
      end
      S_FETCH: begin
        front_d        = rdata_q;
        out_valid_d    = 1'b1;
        out_d.accepted = 1'b1;
        out_d.front    = rdata_q;
        out_d.rear     = rear_q;
        out_d.empty    = 1'b0;
        out_d.full     = (count_q == cap_eff);
        state_d        = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state; a capacity write empties the queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cap_q       <= CAP_RESET;
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cap_q   <= cfg_wdata_i;
        head_q  <= '0;
        count_q <= '0;
      end else begin
        head_q  <= head_d;
        count_q <= count_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    front_q <= front_d;
    rear_q  <= rear_d;
    out_q   <= out_d;
  end

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= req_i.push_value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= mem[raddr];
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.accepted    = out_q.accepted;
  assign rsp_o.front_value = out_q.front;
  assign rsp_o.rear_value  = out_q.rear;
  assign rsp_o.is_empty    = out_q.empty;
  assign rsp_o.is_full     = out_q.full;

  // Fill level stays within the clamped capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= cap_eff)
    else $error("entry count exceeds capacity");

  // Head index stays inside the ring
  assert property (@(posedge clk_i) disable iff (!rst_ni) CNT_W'(head_q) < cap_eff)
    else $error("head index outside ring");

  // Fetch starts with the response slot free and returns to idle with a valid response in the cycle after
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FETCH |-> !out_valid_q ##1 (state_q == S_IDLE && out_valid_q))
    else $error("front fetch sequencing broken");

  // A dequeue that leaves entries must fetch the new front
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && deq_ok && count_q != CNT_W'(1)) |=> state_q == S_FETCH)
    else $error("missing front fetch after dequeue");

endmodule

`default_nettype wire
